// ===== src/wrl_pkg.sv =====
// shared types and constants of the wavelet row lifting unit
// used by wrl_core, wrl_out_fifo and wavelet_row_lifting_unit; depends on nothing
package wrl_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_BITS       = 19;
  localparam int MODE_BITS       = 2;
  localparam int FIFO_DEPTH      = 4;
  localparam int OUT_DATA_BITS   = ((2 * COEF_BITS + 7) / 8) * 8;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LEGALL     = 2'd0,
    MODE_HAAR       = 2'd1,
    MODE_HAAR_SHIFT = 2'd2
  } mode_e;

  typedef struct packed {
    logic                        row_done;
    logic signed [COEF_BITS-1:0] high_coef;
    logic signed [COEF_BITS-1:0] low_coef;
  } res_t;

  // up to two result items per processed input item
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r1;
    res_t       r0;
  } push_t;

endpackage

// ===== src/wrl_core.sv =====
// input register, lifting arithmetic and row state of the wavelet row lifting unit
// depends on wrl_pkg
module wrl_core #(
  parameter int SAMPLE_BITS = wrl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wrl_pkg::MODE_BITS-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    even_i,
  input  logic signed [SAMPLE_BITS-1:0]    odd_i,
  input  logic                             row_end_i,
  input  logic                             room_i,
  output wrl_pkg::push_t                   push_o
);

  localparam int CB = wrl_pkg::COEF_BITS;
  localparam int IW = ((SAMPLE_BITS > CB) ? SAMPLE_BITS : CB) + 4;

  logic [wrl_pkg::MODE_BITS-1:0] mode_q;
  logic                          in_valid_q, in_valid_d;
  logic signed [SAMPLE_BITS-1:0] even_q, odd_q;
  logic                          row_end_q;
  logic signed [SAMPLE_BITS-1:0] held_even_q, held_even_d;
  logic signed [SAMPLE_BITS-1:0] held_odd_q, held_odd_d;
  logic signed [CB-1:0]          earlier_high_q, earlier_high_d;
  logic                          pair_waiting_q, pair_waiting_d;
  logic                          have_high_q, have_high_d;
  logic                          fire, accept;

  logic signed [IW-1:0] e_x, o_x, he_x, ho_x, eh_x;
  logic signed [IW-1:0] e_s, o_s, hh, lh;
  logic signed [IW-1:0] hc, ls, hp, hb, lp, lc;

  function automatic logic signed [IW-1:0] wrap_f(input logic signed [IW-1:0] v);
    wrap_f = IW'($signed(v[CB-1:0]));
  endfunction

  assign fire       = in_valid_q && room_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !in_valid_q || fire;
  assign in_valid_d = accept ? 1'b1 : (fire ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= wrl_pkg::MODE_LEGALL;
      in_valid_q     <= 1'b0;
      held_even_q    <= '0;
      held_odd_q     <= '0;
      earlier_high_q <= '0;
      pair_waiting_q <= 1'b0;
      have_high_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      in_valid_q     <= in_valid_d;
      held_even_q    <= held_even_d;
      held_odd_q     <= held_odd_d;
      earlier_high_q <= earlier_high_d;
      pair_waiting_q <= pair_waiting_d;
      have_high_q    <= have_high_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      even_q    <= even_i;
      odd_q     <= odd_i;
      row_end_q <= row_end_i;
    end
  end

  always_comb begin
    e_x  = IW'(even_q);
    o_x  = IW'(odd_q);
    he_x = IW'(held_even_q);
    ho_x = IW'(held_odd_q);
    eh_x = IW'(earlier_high_q);

    // haar, shifted by one except in the unshifted mode
    e_s = (mode_q == wrl_pkg::MODE_HAAR) ? e_x : (e_x <<< 1);
    o_s = (mode_q == wrl_pkg::MODE_HAAR) ? o_x : (o_x <<< 1);
    hh  = wrap_f(o_s - e_s);
    lh  = wrap_f(e_s + ((hh + IW'(1)) >>> 1));

    // 5/3 with the right neighbour mirrored onto itself
    hc = wrap_f((o_x <<< 1) - (e_x <<< 1));
    ls = wrap_f((e_x <<< 1) + (((hc <<< 1) + IW'(2)) >>> 2));

    // 5/3 for the held pair, now that its right neighbour is known
    hp = wrap_f((ho_x <<< 1) - (((he_x <<< 1) + (e_x <<< 1) + IW'(1)) >>> 1));
    hb = have_high_q ? eh_x : hp;
    lp = wrap_f((he_x <<< 1) + ((hb + hp + IW'(2)) >>> 2));
    lc = wrap_f((e_x <<< 1) + ((hp + hc + IW'(2)) >>> 2));
  end

  always_comb begin
    push_o         = '0;
    held_even_d    = held_even_q;
    held_odd_d     = held_odd_q;
    earlier_high_d = earlier_high_q;
    pair_waiting_d = pair_waiting_q;
    have_high_d    = have_high_q;
    if (fire) begin
      if (mode_q != wrl_pkg::MODE_LEGALL) begin
        push_o.cnt          = 2'd1;
        push_o.r0.low_coef  = lh[CB-1:0];
        push_o.r0.high_coef = hh[CB-1:0];
        push_o.r0.row_done  = row_end_q;
        pair_waiting_d      = 1'b0;
        have_high_d         = 1'b0;
      end else if (!pair_waiting_q) begin
        have_high_d = 1'b0;
        if (row_end_q) begin
          push_o.cnt          = 2'd1;
          push_o.r0.low_coef  = ls[CB-1:0];
          push_o.r0.high_coef = hc[CB-1:0];
          push_o.r0.row_done  = 1'b1;
        end else begin
          held_even_d    = even_q;
          held_odd_d     = odd_q;
          pair_waiting_d = 1'b1;
        end
      end else begin
        push_o.r0.low_coef  = lp[CB-1:0];
        push_o.r0.high_coef = hp[CB-1:0];
        push_o.r0.row_done  = 1'b0;
        if (row_end_q) begin
          push_o.cnt          = 2'd2;
          push_o.r1.low_coef  = lc[CB-1:0];
          push_o.r1.high_coef = hc[CB-1:0];
          push_o.r1.row_done  = 1'b1;
          pair_waiting_d      = 1'b0;
          have_high_d         = 1'b0;
          earlier_high_d      = '0;
        end else begin
          push_o.cnt     = 2'd1;
          held_even_d    = even_q;
          held_odd_d     = odd_q;
          earlier_high_d = hp[CB-1:0];
          have_high_d    = 1'b1;
        end
      end
    end
  end

  // the saved high value is only meaningful while a pair is held
  a_high_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_high_q |-> pair_waiting_q)
    else $error("earlier high valid without a held pair");

  // a stalled input register keeps its item
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !room_i) |=> (in_valid_q && $stable(even_q) && $stable(odd_q)))
    else $error("input register lost an item while stalled");

  // two results only come from the end of a row with a held pair
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt == 2'd2) |-> (pair_waiting_q && row_end_q && fire))
    else $error("double result outside a row flush");

endmodule

// ===== src/wrl_out_fifo.sv =====
// four-entry result queue taking up to two items per cycle, one out per cycle when the reader takes it
// depends on wrl_pkg
module wrl_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wrl_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output wrl_pkg::res_t   out_res_o
);

  localparam int DEPTH = wrl_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  wrl_pkg::res_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CW'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PW'(pop);
    count_d  = count_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[PW'(wr_ptr_q + 1'b1)] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> ((count_q + CW'(push_i.cnt)) <= CW'(DEPTH)))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.cnt == 2'd0) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("result queue count did not drop on a read");

endmodule

// ===== src/wavelet_row_lifting_unit.sv =====
// top level of the wavelet row lifting unit (5/3 with prescale, or haar)
// depends on wrl_pkg, wrl_core and wrl_out_fifo
//
// usage:
// - slave stream: tdata = {odd_sample, even_sample} (even in the low bits), tlast = row_end.
// - master stream: tdata = {pad, high_coef, low_coef}, tlast = row_done.
// - cfg_we_i/cfg_wdata_i write the mode (0 5/3, 1 haar, 2 or 3 haar with shift)
//   while the unit is idle; there is no read-back.
// - an item is taken into an input register, processed from there once the result
//   queue has room and written to a four-entry result queue; the earliest result
//   reaches the master side through the input register and the result queue.
// - in 5/3 mode the results lag one pair and the last pair of a row gives two
//   results; haar and one-pair rows give one result per item.
// - sustained rate is one item per cycle while the result queue has room; a row-end flush
//   in 5/3 mode gives two results, which the single read port of the result queue passes on one after the other.
// - when the receiver stalls, the queue takes results while it holds two or fewer
//   (up to four in all), then the input register fills and tready drops; nothing is lost.
// - reset clears the mode to 5/3, empties the queue and starts a fresh row.
module wavelet_row_lifting_unit #(
  parameter int SAMPLE_BITS = wrl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrl_pkg::MODE_BITS-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // even_sample, odd_sample, zero fill
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // low_coef, high_coef, zero fill
  output logic [wrl_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int CB = wrl_pkg::COEF_BITS;

  wrl_pkg::push_t push;
  wrl_pkg::res_t  res;
  logic           room;

  wrl_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .even_i      ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .odd_i       ($signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .row_end_i   (s_axis_tlast),
    .room_i      (room),
    .push_o      (push)
  );

  wrl_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = {{(wrl_pkg::OUT_DATA_BITS - 2*CB){1'b0}}, res.high_coef, res.low_coef};
  assign m_axis_tlast = res.row_done;

endmodule

// ===== tb/sv/testbench.sv =====
// stream testbench for wavelet_row_lifting_unit: directed rows, random rows and stalls
// needs wrl_pkg and the unit's rtl; predicts each coefficient item and checks it on arrival
`timescale 1ns / 100ps

module testbench;

  localparam logic [wrl_pkg::MODE_BITS-1:0] MODE_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [wrl_pkg::MODE_BITS-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [wrl_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tlast;

  // predictor state
  logic [wrl_pkg::MODE_BITS-1:0] lift_mode = wrl_pkg::MODE_LEGALL;
  logic signed [15:0] prev_even = '0;
  logic signed [15:0] prev_odd = '0;
  logic signed [wrl_pkg::COEF_BITS-1:0] last_high = '0;
  bit pair_held = 1'b0;
  bit high_valid = 1'b0;

  wrl_pkg::res_t pending_coefs[$];
  int fault_count = 0;
  bit idle_on = 1'b1;
  int hold_request = 0;

  wavelet_row_lifting_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint wrap_coef(longint v);
    logic signed [wrl_pkg::COEF_BITS-1:0] t;
    t = v[wrl_pkg::COEF_BITS-1:0];
    return t;
  endfunction

  function automatic void push_coef(longint lo, longint hi, bit done);
    wrl_pkg::res_t r;
    r.low_coef = lo[wrl_pkg::COEF_BITS-1:0];
    r.high_coef = hi[wrl_pkg::COEF_BITS-1:0];
    r.row_done = done;
    pending_coefs.push_back(r);
  endfunction

  // forward lifting of one accepted pair, queues what it produces
  function automatic void lift_pair(logic signed [15:0] e, logic signed [15:0] o, bit last);
    longint ev, ov, pe, po, s, hi, lo, hp, hb, hc;
    ev = e;
    ov = o;
    pe = prev_even;
    po = prev_odd;
    if (lift_mode != wrl_pkg::MODE_LEGALL) begin
      s = (lift_mode == wrl_pkg::MODE_HAAR) ? 1 : 2;
      hi = wrap_coef(ov * s - ev * s);
      lo = wrap_coef(ev * s + ((hi + 1) >>> 1));
      pair_held = 1'b0;
      high_valid = 1'b0;
      push_coef(lo, hi, last);
    end else if (!pair_held) begin
      if (last) begin
        // lone pair, mirrored on both sides
        hi = wrap_coef(2 * ov - 2 * ev);
        lo = wrap_coef(2 * ev + ((2 * hi + 2) >>> 2));
        high_valid = 1'b0;
        push_coef(lo, hi, 1'b1);
      end else begin
        prev_even = e;
        prev_odd = o;
        pair_held = 1'b1;
        high_valid = 1'b0;
      end
    end else begin
      hp = wrap_coef(2 * po - ((2 * pe + 2 * ev + 1) >>> 1));
      hb = high_valid ? longint'(last_high) : hp;
      push_coef(wrap_coef(2 * pe + ((hb + hp + 2) >>> 2)), hp, 1'b0);
      if (last) begin
        hc = wrap_coef(2 * ov - 2 * ev);
        push_coef(wrap_coef(2 * ev + ((hp + hc + 2) >>> 2)), hc, 1'b1);
        pair_held = 1'b0;
        high_valid = 1'b0;
        last_high = '0;
      end else begin
        prev_even = e;
        prev_odd = o;
        last_high = hp[wrl_pkg::COEF_BITS-1:0];
        high_valid = 1'b1;
      end
    end
  endfunction

  function automatic logic signed [15:0] rand_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 15)) - 8);
      default: return r[15:0];
    endcase
  endfunction

  task automatic send_pair(logic signed [15:0] e, logic signed [15:0] o, bit last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {o, e};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    lift_pair(e, o, last);
  endtask

  // stop offering, let every expected item arrive and the pipeline settle
  task automatic drain_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(logic [wrl_pkg::MODE_BITS-1:0] m);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lift_mode = m;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        // the loop edge also counts as idle
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    wrl_pkg::res_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_coefs.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected item: low %0d high %0d done %0b",
                     $signed(m_axis_tdata[wrl_pkg::COEF_BITS-1:0]),
                     $signed(m_axis_tdata[2*wrl_pkg::COEF_BITS-1:wrl_pkg::COEF_BITS]),
                     m_axis_tlast);
        end else begin
          want = pending_coefs.pop_front();
          if (want.low_coef !== m_axis_tdata[wrl_pkg::COEF_BITS-1:0] ||
              want.high_coef !== m_axis_tdata[2*wrl_pkg::COEF_BITS-1:wrl_pkg::COEF_BITS] ||
              want.row_done !== m_axis_tlast) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch: want low %0d high %0d done %0b, got low %0d high %0d done %0b",
                       want.low_coef, want.high_coef, want.row_done,
                       $signed(m_axis_tdata[wrl_pkg::COEF_BITS-1:0]),
                       $signed(m_axis_tdata[2*wrl_pkg::COEF_BITS-1:wrl_pkg::COEF_BITS]),
                       m_axis_tlast);
          end
        end
      end
    end
  end

  task automatic test_legall_edges();
    // one-pair rows and short rows, mostly at the extremes
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh0000, 16'sh0000, 1'b1);
  endtask

  task automatic test_haar_edges();
    set_mode(wrl_pkg::MODE_HAAR);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    set_mode(wrl_pkg::MODE_HAAR_SHIFT);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    set_mode(MODE_RESERVED);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 1'b0);
  endtask

  task automatic test_mode_switch();
    set_mode(wrl_pkg::MODE_LEGALL);
    send_pair(16'sd100, -16'sd7, 1'b0);
    send_pair(-16'sd3, 16'sd55, 1'b0);
    // haar step drops the held pair
    set_mode(wrl_pkg::MODE_HAAR);
    send_pair(16'sd9, -16'sd9, 1'b1);
    set_mode(wrl_pkg::MODE_LEGALL);
    send_pair(16'sd1234, -16'sd4321, 1'b0);
    // writes alone keep the held pair
    set_mode(wrl_pkg::MODE_HAAR_SHIFT);
    set_mode(wrl_pkg::MODE_LEGALL);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd7, 16'sd8, 1'b1);
  endtask

  task automatic test_random_rows(int n_items);
    int sent;
    int phase;
    int row_len;
    logic [wrl_pkg::MODE_BITS-1:0] m;
    bit last;
    sent = 0;
    phase = 0;
    while (sent < n_items) begin
      if (phase < 4) m = phase[wrl_pkg::MODE_BITS-1:0];
      else if ($urandom_range(0, 9) < 6) m = wrl_pkg::MODE_LEGALL;
      else m = wrl_pkg::MODE_BITS'($urandom_range(1, 3));
      set_mode(m);
      phase++;
      repeat ($urandom_range(3, 8)) begin
        row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
        for (int k = 0; k < row_len; k++) begin
          last = (k == row_len - 1);
          // occasional broken row
          if ($urandom_range(0, 19) == 0) last = ~last;
          send_pair(rand_sample(), rand_sample(), last);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    set_mode(wrl_pkg::MODE_LEGALL);
    hold_request = LONG_HOLD_CYCLES;
    for (int k = 0; k < 30; k++)
      send_pair(rand_sample(), rand_sample(), (k % 3) == 2);
  endtask

  task automatic test_sender_pause();
    for (int k = 0; k < 5; k++)
      send_pair(rand_sample(), rand_sample(), k == 4);
    drain_results();
    for (int k = 0; k < 5; k++)
      send_pair(rand_sample(), rand_sample(), k == 1 || k == 4);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_mode(wrl_pkg::MODE_LEGALL);
    for (int k = 0; k < 30; k++)
      send_pair(rand_sample(), rand_sample(), (k % 4) == 3);
    set_mode(wrl_pkg::MODE_HAAR_SHIFT);
    for (int k = 0; k < 10; k++)
      send_pair(rand_sample(), rand_sample(), k == 9);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_legall_edges();
    test_haar_edges();
    test_mode_switch();
    test_random_rows(560);
    test_backpressure();
    test_sender_pause();
    test_steady_stream();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (fault_count == 0 && pending_coefs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
